@@ design/running_variance_merge_macros.svh @@
// Assertion macros for the running variance merge block.
// The including scope must provide clk and arst_n.
`ifndef RUNNING_VARIANCE_MERGE_MACROS_SVH
`define RUNNING_VARIANCE_MERGE_MACROS_SVH

`define RVM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`define RVM_ASSERT_NEXT(label, pre, post, msg) \
	`RVM_ASSERT(label, (pre) |=> (post), msg)

`endif

@@ design/rvm_pkg.sv @@
// Shared widths, types and helpers for the running variance merge block.
// No dependencies; every other file of the block but the macros header imports this package.
package rvm_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int CH_W = 3;
	localparam int MEAN_W = 32;
	localparam int M2_W = 64;
	localparam int BCNT_W = 32;
	localparam int CNT_W = 40;
	localparam int SUM_W = CNT_W + 1;
	localparam int RES_W = 32;

	localparam int MUL_A_W = CNT_W + BCNT_W;
	localparam int MUL_B_W = M2_W;
	localparam int PROD_W = MUL_A_W + MUL_B_W;

	localparam int DIV_N_W = PROD_W;
	localparam int DIV_Q_W = M2_W;
	localparam int DIV_LEN_W = $clog2(DIV_N_W + 1);

	localparam int SQ_IN_W = M2_W;
	localparam int SQ_OUT_W = SQ_IN_W / 2;
	localparam int SQ_REM_W = SQ_OUT_W + 2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_MMUL,
		S_MDIV,
		S_DMUL,
		S_PMUL,
		S_XMUL,
		S_XDIV,
		S_WB,
		S_SQ1,
		S_EDIV,
		S_RDIV,
		S_SQ2,
		S_EMIT
	} rvm_state_t;

	typedef struct packed {
		logic start;
		logic [DIV_LEN_W-1:0] len;
		logic [DIV_N_W-1:0] num;
		logic [SUM_W-1:0] den;
	} rvm_div_cmd_t;

	typedef struct packed {
		logic done;
		logic ovf;
		logic [DIV_Q_W-1:0] quo;
	} rvm_div_rsp_t;

	function automatic logic [M2_W-1:0] sat_add(input logic [M2_W-1:0] a,
		input logic [M2_W-1:0] b);
		logic [M2_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[M2_W] ? '1 : s[M2_W-1:0];
	endfunction

endpackage

@@ design/rvm_in_if.sv @@
// Input channel of the running variance merge block: one partial statistic per beat.
// Depends on rvm_pkg for the field widths.
interface rvm_in_if import rvm_pkg::*; ();
	logic valid;
	logic ready;
	logic [CH_W-1:0] channel;
	logic signed [MEAN_W-1:0] burst_mean;
	logic [M2_W-1:0] burst_m2;
	logic [BCNT_W-1:0] burst_count;
	logic end_of_run;

	modport source(output valid, channel, burst_mean, burst_m2, burst_count, end_of_run,
		input ready);
	modport sink(input valid, channel, burst_mean, burst_m2, burst_count, end_of_run,
		output ready);
endinterface

@@ design/rvm_out_if.sv @@
// Output channel of the running variance merge block: one channel summary per beat.
// Depends on rvm_pkg for the field widths.
interface rvm_out_if import rvm_pkg::*; ();
	logic valid;
	logic ready;
	logic [CH_W-1:0] out_channel;
	logic signed [MEAN_W-1:0] run_mean;
	logic [RES_W-1:0] run_error;
	logic [RES_W-1:0] run_rms;
	logic [CNT_W-1:0] run_count;

	modport source(output valid, out_channel, run_mean, run_error, run_rms, run_count,
		input ready);
	modport sink(input valid, out_channel, run_mean, run_error, run_rms, run_count,
		output ready);
endinterface

@@ design/rvm_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on rvm_pkg for operand and product widths.
module rvm_mul import rvm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [MUL_A_W-1:0] a,
	input logic [MUL_B_W-1:0] b,
	output logic done,
	output logic [PROD_W-1:0] prod
);
	localparam int CNT_BITS = $clog2(MUL_B_W);

	logic [MUL_A_W-1:0] a_q;
	logic [MUL_A_W-1:0] hi_q;
	logic [MUL_B_W-1:0] lo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [MUL_A_W:0] sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[MUL_A_W:1];
			lo_q <= {sum[0], lo_q[MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};
endmodule

@@ design/rvm_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, with a quotient overflow flag.
// Depends on rvm_pkg for the command and response structs.
module rvm_div import rvm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input rvm_div_cmd_t cmd,
	output rvm_div_rsp_t rsp
);
	logic [DIV_N_W-1:0] num_q;
	logic [SUM_W-1:0] den_q;
	logic [SUM_W-1:0] rem_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic ovf_q;
	logic [DIV_LEN_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [SUM_W:0] trial;
	logic [SUM_W:0] diff;
	logic ge;

	assign trial = {rem_q, num_q[DIV_N_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= cmd.len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_LEN_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_q <= cmd.num;
			den_q <= cmd.den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_N_W-2:0], 1'b0};
			rem_q <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
			quo_q <= {quo_q[DIV_Q_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[DIV_Q_W-1];
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf = ovf_q;
	assign rsp.quo = quo_q;
endmodule

@@ design/rvm_sqrt.sv @@
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on rvm_pkg for the radicand and root widths.
module rvm_sqrt import rvm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [SQ_IN_W-1:0] op,
	output logic done,
	output logic [SQ_OUT_W-1:0] root
);
	localparam int CNT_BITS = $clog2(SQ_OUT_W);

	logic [SQ_IN_W-1:0] op_q;
	logic [SQ_REM_W-1:0] rem_q;
	logic [SQ_OUT_W-1:0] root_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [SQ_REM_W+1:0] t;
	logic [SQ_REM_W+1:0] trial;
	logic [SQ_REM_W+1:0] diff;
	logic ge;

	assign t = {rem_q, op_q[SQ_IN_W-1:SQ_IN_W-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff = t - trial;
	assign ge = (t >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(SQ_OUT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= op;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			op_q <= {op_q[SQ_IN_W-3:0], 2'b00};
			rem_q <= ge ? diff[SQ_REM_W-1:0] : t[SQ_REM_W-1:0];
			root_q <= {root_q[SQ_OUT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

@@ design/running_variance_merge.sv @@
// Top level of the running variance merge block: accumulators, sequencer and output register.
// Depends on rvm_pkg, rvm_in_if, rvm_out_if, rvm_mul, rvm_div and rvm_sqrt.
//
// Usage:
// The stat channel takes one partial statistic per beat (channel, mean, m2, count and
// an end_of_run flag) and merges it into that channel's accumulator. A beat with
// end_of_run set also yields one beat on the summary channel with the merged mean, the
// error, the rms and the count, after which the channel's accumulator is cleared.
// A beat for a channel at or above CHANNELS is accepted and dropped.
// The block works on one beat at a time, and stat.ready is high only while idle.
// A merge with a nonzero combined count runs four 64-step serial multiplies and a
// 64-step and a 136-step serial division, all one bit per cycle. A zero combined
// count skips them and goes straight to the write-back. A summary adds two 32-step
// square roots and a 32-step and a 64-step division.
// The summary sits in an output register; the next stat beat is taken while it waits.
// A stalled receiver holds up a later summary, which waits in the final state, and with it every later stat beat.
// Reset clears all accumulators to zero and empties the output register.
module running_variance_merge import rvm_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	rvm_in_if.sink stat,
	rvm_out_if.source summary
);
	localparam int NCH = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
	localparam int IDXW = (NCH > 1) ? $clog2(NCH) : 1;

	rvm_state_t state_q, state_d;
	logic wait_q;

	logic signed [MEAN_W-1:0] acc_mean_q [NCH];
	logic [M2_W-1:0] acc_m2_q [NCH];
	logic [CNT_W-1:0] acc_count_q [NCH];

	logic [CH_W-1:0] ch_q;
	logic in_range_q;
	logic signed [MEAN_W-1:0] mean2_q;
	logic [M2_W-1:0] m2b_q;
	logic [BCNT_W-1:0] n2_q;
	logic eor_q;

	logic signed [MEAN_W-1:0] m1_q;
	logic [CNT_W-1:0] n1_q;
	logic [SUM_W-1:0] n_q;
	logic [MEAN_W-1:0] mag_q;
	logic neg_q;
	logic [M2_W-1:0] m2sum_q;
	logic signed [MEAN_W-1:0] mean_new_q;
	logic [M2_W-1:0] m2_new_q;
	logic [M2_W-1:0] d2_q;
	logic [MUL_A_W-1:0] p_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SQ_OUT_W-1:0] rt_q;
	logic [RES_W-1:0] err_q;
	logic [RES_W-1:0] rms_q;

	logic out_valid_q;
	logic [CH_W-1:0] out_ch_q;
	logic signed [MEAN_W-1:0] out_mean_q;
	logic [RES_W-1:0] out_err_q;
	logic [RES_W-1:0] out_rms_q;
	logic [CNT_W-1:0] out_cnt_q;

	logic [IDXW-1:0] idx;
	logic signed [MEAN_W-1:0] m1;
	logic [CNT_W-1:0] n1;
	logic [SUM_W-1:0] n_sum;
	logic signed [MEAN_W:0] delta;
	logic [MEAN_W:0] delta_abs;
	logic [M2_W-1:0] m2_sat;
	logic [CNT_W-1:0] cnt_sat;
	logic [MEAN_W-1:0] q_mean;
	logic accept;
	logic emit_go;

	logic mul_start;
	logic mul_done;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0] mul_prod;
	logic div_start;
	rvm_div_cmd_t div_cmd;
	rvm_div_rsp_t div_rsp;
	logic sq_start;
	logic sq_done;
	logic [SQ_IN_W-1:0] sq_op;
	logic [SQ_OUT_W-1:0] sq_root;

	assign accept = stat.valid && stat.ready;
	assign stat.ready = (state_q == S_IDLE);
	assign emit_go = !out_valid_q || summary.ready;

	assign idx = ch_q[IDXW-1:0];
	assign m1 = acc_mean_q[idx];
	assign n1 = acc_count_q[idx];
	assign n_sum = {1'b0, n1} + SUM_W'(n2_q);
	assign delta = {mean2_q[MEAN_W-1], mean2_q} - {m1[MEAN_W-1], m1};
	assign delta_abs = delta[MEAN_W] ? -delta : delta;
	assign m2_sat = sat_add(acc_m2_q[idx], m2b_q);
	assign cnt_sat = n_q[SUM_W-1] ? '1 : n_q[CNT_W-1:0];
	assign q_mean = div_rsp.quo[MEAN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_start || div_start || sq_start) begin
				wait_q <= 1'b1;
			end else if (mul_done || div_rsp.done || sq_done) begin
				wait_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		mul_start = 1'b0;
		sq_start = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (stat.valid) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				if (!in_range_q) begin
					state_d = S_IDLE;
				end else if (n_sum == '0) begin
					state_d = S_WB;
				end else begin
					state_d = S_MMUL;
				end
			end
			S_MMUL: begin
				mul_start = !wait_q;
				if (mul_done) begin
					state_d = S_MDIV;
				end
			end
			S_MDIV: begin
				div_start = !wait_q;
				if (div_rsp.done) begin
					state_d = S_DMUL;
				end
			end
			S_DMUL: begin
				mul_start = !wait_q;
				if (mul_done) begin
					state_d = S_PMUL;
				end
			end
			S_PMUL: begin
				mul_start = !wait_q;
				if (mul_done) begin
					state_d = S_XMUL;
				end
			end
			S_XMUL: begin
				mul_start = !wait_q;
				if (mul_done) begin
					state_d = S_XDIV;
				end
			end
			S_XDIV: begin
				div_start = !wait_q;
				if (div_rsp.done) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				if (!eor_q) begin
					state_d = S_IDLE;
				end else if (cnt_sat == '0) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_SQ1;
				end
			end
			S_SQ1: begin
				sq_start = !wait_q;
				if (sq_done) begin
					state_d = S_EDIV;
				end
			end
			S_EDIV: begin
				div_start = !wait_q;
				if (div_rsp.done) begin
					state_d = S_RDIV;
				end
			end
			S_RDIV: begin
				div_start = !wait_q;
				if (div_rsp.done) begin
					state_d = S_SQ2;
				end
			end
			S_SQ2: begin
				sq_start = !wait_q;
				if (sq_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (emit_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		div_cmd.start = div_start;
		case (state_q)
			S_MMUL: begin
				mul_a = MUL_A_W'(mag_q);
				mul_b = MUL_B_W'(n2_q);
			end
			S_DMUL: begin
				mul_a = MUL_A_W'(mag_q);
				mul_b = MUL_B_W'(mag_q);
			end
			S_PMUL: begin
				mul_a = MUL_A_W'(n1_q);
				mul_b = MUL_B_W'(n2_q);
			end
			default: begin
				mul_a = p_q;
				mul_b = d2_q;
			end
		endcase
		case (state_q)
			S_MDIV: begin
				div_cmd.num = {mul_prod[M2_W-1:0], {(DIV_N_W - M2_W){1'b0}}};
				div_cmd.len = DIV_LEN_W'(M2_W);
				div_cmd.den = n_q;
			end
			S_EDIV: begin
				div_cmd.num = {rt_q, {(DIV_N_W - SQ_OUT_W){1'b0}}};
				div_cmd.len = DIV_LEN_W'(SQ_OUT_W);
				div_cmd.den = {1'b0, cnt_q};
			end
			S_RDIV: begin
				div_cmd.num = {m2_new_q, {(DIV_N_W - M2_W){1'b0}}};
				div_cmd.len = DIV_LEN_W'(M2_W);
				div_cmd.den = {1'b0, cnt_q};
			end
			default: begin
				div_cmd.num = mul_prod;
				div_cmd.len = DIV_LEN_W'(DIV_N_W);
				div_cmd.den = n_q;
			end
		endcase
		sq_op = (state_q == S_SQ2) ? div_rsp.quo : m2_new_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= stat.channel;
			in_range_q <= ({1'b0, stat.channel} < (CH_W + 1)'(NCH));
			mean2_q <= stat.burst_mean;
			m2b_q <= stat.burst_m2;
			n2_q <= stat.burst_count;
			eor_q <= stat.end_of_run;
		end
		case (state_q)
			S_LOAD: begin
				m1_q <= m1;
				n1_q <= n1;
				n_q <= n_sum;
				mag_q <= delta_abs[MEAN_W-1:0];
				neg_q <= delta[MEAN_W];
				m2sum_q <= m2_sat;
				mean_new_q <= m1;
				m2_new_q <= m2_sat;
			end
			S_MDIV: begin
				if (div_rsp.done) begin
					mean_new_q <= neg_q ? m1_q - $signed(q_mean) : m1_q + $signed(q_mean);
				end
			end
			S_DMUL: begin
				if (mul_done) begin
					d2_q <= mul_prod[M2_W-1:0];
				end
			end
			S_PMUL: begin
				if (mul_done) begin
					p_q <= mul_prod[MUL_A_W-1:0];
				end
			end
			S_XDIV: begin
				if (div_rsp.done) begin
					m2_new_q <= div_rsp.ovf ? '1 : sat_add(m2sum_q, div_rsp.quo);
				end
			end
			S_WB: begin
				cnt_q <= cnt_sat;
				err_q <= '0;
				rms_q <= '0;
			end
			S_SQ1: begin
				if (sq_done) begin
					rt_q <= sq_root;
				end
			end
			S_EDIV: begin
				if (div_rsp.done) begin
					err_q <= div_rsp.quo[RES_W-1:0];
				end
			end
			S_SQ2: begin
				if (sq_done) begin
					rms_q <= RES_W'(sq_root);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				acc_mean_q[i] <= '0;
				acc_m2_q[i] <= '0;
				acc_count_q[i] <= '0;
			end
		end else if (state_q == S_WB) begin
			acc_mean_q[idx] <= eor_q ? '0 : mean_new_q;
			acc_m2_q[idx] <= eor_q ? '0 : m2_new_q;
			acc_count_q[idx] <= eor_q ? '0 : cnt_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && emit_go) begin
			out_valid_q <= 1'b1;
		end else if (summary.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && emit_go) begin
			out_ch_q <= ch_q;
			out_mean_q <= mean_new_q;
			out_err_q <= err_q;
			out_rms_q <= rms_q;
			out_cnt_q <= cnt_q;
		end
	end

	assign summary.valid = out_valid_q;
	assign summary.out_channel = out_ch_q;
	assign summary.run_mean = out_mean_q;
	assign summary.run_error = out_err_q;
	assign summary.run_rms = out_rms_q;
	assign summary.run_count = out_cnt_q;

	rvm_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.done(mul_done),
		.prod(mul_prod)
	);

	rvm_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(div_cmd),
		.rsp(div_rsp)
	);

	rvm_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_start),
		.op(sq_op),
		.done(sq_done),
		.root(sq_root)
	);
endmodule

@@ design/rvm_checker.sv @@
// Port-level checks for the running variance merge block, bound to its top level.
// Depends on rvm_pkg and the assertion macros header.
`include "running_variance_merge_macros.svh"

module rvm_checker import rvm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [RES_W-1:0] out_error,
	input logic [RES_W-1:0] out_rms,
	input logic [CNT_W-1:0] out_count
);
	// The block works on one beat at a time, so ready drops after every accepted beat.
	`RVM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high")
	`RVM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "summary beat dropped")
	`RVM_ASSERT(a_zero_count, (out_valid && out_count == '0) |-> (out_error == '0 && out_rms == '0), "nonzero error or rms at zero count")
	`RVM_ASSERT(a_err_le_rms, out_valid |-> (out_error <= out_rms), "error exceeds rms")
endmodule

bind running_variance_merge rvm_checker u_rvm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(stat.valid),
	.in_ready(stat.ready),
	.out_valid(summary.valid),
	.out_ready(summary.ready),
	.out_error(summary.run_error),
	.out_rms(summary.run_rms),
	.out_count(summary.run_count)
);
